/* design/cru_pkg.sv */
// ----------------------------------------------------------------------------
// cru_pkg
// Shared widths and types for the circumcircle unit.
// ----------------------------------------------------------------------------
package cru_pkg;

  localparam int COORD_BITS = 24;
  localparam int OUT_BITS   = 32;

  // point deltas relative to the start point
  localparam int DB  = COORD_BITS + 1;
  // squared length of a delta
  localparam int SW  = 2 * DB;
  // low split of a squared length
  localparam int HW  = DB;
  // half product: (HW+1) signed x DB signed
  localparam int PPW = HW + 1 + DB;
  // full product squared-length x delta
  localparam int PW  = SW + DB + 1;
  // numerators and denominator
  localparam int NW  = PW + 1;
  localparam int DW  = 2 * DB + 2;
  // quotient magnitude bits kept before saturation
  localparam int QB  = OUT_BITS + 1;
  localparam int QW  = QB + 1;
  localparam int CW  = NW + QB;
  localparam int DIV_LAT = QB + 1;
  // radius path
  localparam int DXW = OUT_BITS + 1;
  localparam int SMW = 2 * DXW;
  localparam int RB  = DXW;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
  } pts_t;

  typedef struct packed {
    pts_t            pts;
    logic [DW-1:0]   den;
    logic [NW-1:0]   num_x;
    logic [NW-1:0]   num_y;
    logic            collinear;
  } job_t;

  typedef struct packed {
    pts_t                pts;
    logic                collinear;
    logic [OUT_BITS-1:0] ctr_x;
    logic [OUT_BITS-1:0] ctr_y;
    logic [OUT_BITS-1:0] radius;
    logic                overflow;
  } bk_t;

endpackage

/* design/cru_if.sv */
// ----------------------------------------------------------------------------
// cru_if
// Request channels of the circumcircle unit: arc points in, circle out.
// ----------------------------------------------------------------------------
interface cru_arc_if import cru_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] mid_x;
  logic signed [COORD_BITS-1:0] mid_y;
  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;

  modport source (output valid, first_x, first_y, mid_x, mid_y, last_x, last_y,
                  input ready);
  modport sink   (input valid, first_x, first_y, mid_x, mid_y, last_x, last_y,
                  output ready);
endinterface

interface cru_circle_if import cru_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_first_x;
  logic signed [COORD_BITS-1:0] out_first_y;
  logic signed [COORD_BITS-1:0] out_last_x;
  logic signed [COORD_BITS-1:0] out_last_y;
  logic signed [OUT_BITS-1:0]   ctr_x;
  logic signed [OUT_BITS-1:0]   ctr_y;
  logic        [OUT_BITS-1:0]   radius;
  logic                         collinear;
  logic                         overflow;

  modport source (output valid, out_first_x, out_first_y, out_last_x, out_last_y,
                  ctr_x, ctr_y, radius, collinear, overflow,
                  input ready);
  modport sink   (input valid, out_first_x, out_first_y, out_last_x, out_last_y,
                  ctr_x, ctr_y, radius, collinear, overflow,
                  output ready);
endinterface

/* design/cru_front.sv */
// ----------------------------------------------------------------------------
// cru_front
// Six-stage front: deltas, products, numerators and denominator, collinear
// classification. Stalls as a whole while the queue is full.
// ----------------------------------------------------------------------------
module cru_front import cru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cru_arc_if.sink    arc,
  input  logic       full,
  output logic       push,
  output job_t       job
);

  localparam int NS = 6;

  logic          adv;
  logic [NS-1:0] vld;
  pts_t          pts [NS];

  logic signed [DB-1:0]  dbx1, dby1, dcx1, dcy1;
  logic signed [DB-1:0]  dbx2, dby2, dcx2, dcy2;
  logic signed [DB-1:0]  dbx3, dby3, dcx3, dcy3;
  logic signed [SW-1:0]  pbc2, pcb2;
  logic        [SW-1:0]  qbx2, qby2, qcx2, qcy2;
  logic        [SW-1:0]  sb3, sc3;
  logic signed [DW-1:0]  den3, den4, den5, den6;
  logic signed [PPW-1:0] pal, pah, pbl, pbh, pcl, pch, pdl, pdh;
  logic signed [PW-1:0]  pa, pb, pc, pd;
  logic signed [NW-1:0]  nx6, ny6;
  logic                  col6;

  assign adv       = !full;
  assign arc.ready = adv;
  assign push      = vld[NS-1] && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], arc.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts[0] <= '{arc.first_x, arc.first_y, arc.last_x, arc.last_y};
      for (int i = 1; i < NS; i++) begin
        pts[i] <= pts[i-1];
      end
      // stage 1: deltas from the start point
      dbx1 <= {arc.mid_x[COORD_BITS-1], arc.mid_x} - {arc.first_x[COORD_BITS-1], arc.first_x};
      dby1 <= {arc.mid_y[COORD_BITS-1], arc.mid_y} - {arc.first_y[COORD_BITS-1], arc.first_y};
      dcx1 <= {arc.last_x[COORD_BITS-1], arc.last_x} - {arc.first_x[COORD_BITS-1], arc.first_x};
      dcy1 <= {arc.last_y[COORD_BITS-1], arc.last_y} - {arc.first_y[COORD_BITS-1], arc.first_y};
      // stage 2: cross terms and squares
      pbc2 <= dbx1 * dcy1;
      pcb2 <= dby1 * dcx1;
      qbx2 <= dbx1 * dbx1;
      qby2 <= dby1 * dby1;
      qcx2 <= dcx1 * dcx1;
      qcy2 <= dcy1 * dcy1;
      dbx2 <= dbx1; dby2 <= dby1; dcx2 <= dcx1; dcy2 <= dcy1;
      // stage 3: denominator and squared lengths
      den3 <= (DW'(pbc2) - DW'(pcb2)) <<< 1;
      sb3  <= qbx2 + qby2;
      sc3  <= qcx2 + qcy2;
      dbx3 <= dbx2; dby3 <= dby2; dcx3 <= dcx2; dcy3 <= dcy2;
      // stage 4: split products
      pal  <= $signed({1'b0, sb3[HW-1:0]}) * dcy3;
      pah  <= $signed({1'b0, sb3[SW-1:HW]}) * dcy3;
      pbl  <= $signed({1'b0, sc3[HW-1:0]}) * dby3;
      pbh  <= $signed({1'b0, sc3[SW-1:HW]}) * dby3;
      pcl  <= $signed({1'b0, sc3[HW-1:0]}) * dbx3;
      pch  <= $signed({1'b0, sc3[SW-1:HW]}) * dbx3;
      pdl  <= $signed({1'b0, sb3[HW-1:0]}) * dcx3;
      pdh  <= $signed({1'b0, sb3[SW-1:HW]}) * dcx3;
      den4 <= den3;
      // stage 5: recombine halves
      pa   <= (PW'(pah) <<< HW) + PW'(pal);
      pb   <= (PW'(pbh) <<< HW) + PW'(pbl);
      pc   <= (PW'(pch) <<< HW) + PW'(pcl);
      pd   <= (PW'(pdh) <<< HW) + PW'(pdl);
      den5 <= den4;
      // stage 6: numerators, classification
      nx6  <= NW'(pa) - NW'(pb);
      ny6  <= NW'(pc) - NW'(pd);
      den6 <= den5;
      col6 <= (den5 == '0);
    end
  end

  always_comb begin
    job.pts       = pts[NS-1];
    job.den       = den6;
    job.num_x     = nx6;
    job.num_y     = ny6;
    job.collinear = col6;
  end

endmodule

/* design/cru_fifo.sv */
// ----------------------------------------------------------------------------
// cru_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module cru_fifo import cru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic full,
  output logic avail
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;
  logic [FIFO_AW:0]   cnt;

  assign full  = (cnt == (FIFO_AW+1)'(FIFO_DEPTH));
  assign avail = (cnt != '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* design/cru_div.sv */
// ----------------------------------------------------------------------------
// cru_div
// Pipelined signed divider, truncating, one quotient bit per stage.
// big is set when the quotient magnitude needs more than QB bits; inexact is
// set when the remainder is nonzero.
// ----------------------------------------------------------------------------
module cru_div import cru_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [QW-1:0] q,
  output logic                 big,
  output logic                 neg,
  output logic                 inexact
);

  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] dm  [QB+1];
  logic [QB-1:0] qt  [QB+1];
  logic          ng  [QB+1];
  logic          bg  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[NW-1] ? NW'(-num) : NW'(num);
      dm[0]  <= den[DW-1] ? DW'(-den) : DW'(den);
      ng[0]  <= num[NW-1] ^ den[DW-1];
      qt[0]  <= '0;
      bg[0]  <= 1'b0;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int K = QB - s;
    logic [CW-1:0] rw, cmp;
    logic          ge;
    logic [QB-1:0] qn;

    always_comb begin
      rw    = CW'(rem[s-1]);
      cmp   = CW'(dm[s-1]) << K;
      ge    = (rw >= cmp);
      qn    = qt[s-1];
      qn[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? NW'(rw - cmp) : rem[s-1];
        qt[s]  <= qn;
        dm[s]  <= dm[s-1];
        ng[s]  <= ng[s-1];
      end
    end

    if (s == 1) begin : g_big
      always_ff @(posedge clk) begin
        if (en) bg[s] <= (CW'(rem[0]) >= (CW'(dm[0]) << QB));
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) bg[s] <= bg[s-1];
      end
    end
  end

  assign q       = ng[QB] ? QW'(QW'(0) - QW'(qt[QB])) : QW'(qt[QB]);
  assign big     = bg[QB];
  assign neg     = ng[QB];
  assign inexact = (rem[QB] != '0);

endmodule

/* design/cru_sqrt.sv */
// ----------------------------------------------------------------------------
// cru_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cru_sqrt import cru_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [SMW-1:0] num,
  output logic [RB-1:0]  root
);

  logic [SMW-1:0] rem  [RB];
  logic [RB-1:0]  rt   [RB];
  logic [SMW-1:0] prem [RB];
  logic [RB-1:0]  prt  [RB];

  for (genvar j = 0; j < RB; j++) begin : g_stage
    localparam int I = RB - 1 - j;
    logic [SMW:0]  inc, rw;
    logic          ge;
    logic [RB-1:0] rn;

    if (j == 0) begin : g_first
      assign prem[j] = num;
      assign prt[j]  = '0;
    end else begin : g_next
      assign prem[j] = rem[j-1];
      assign prt[j]  = rt[j-1];
    end

    always_comb begin
      rw    = (SMW+1)'(prem[j]);
      inc   = ((SMW+1)'(prt[j]) << (I + 1)) + ((SMW+1)'(1) << (2 * I));
      ge    = (rw >= inc);
      rn    = prt[j];
      rn[I] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? SMW'(rw - inc) : prem[j];
        rt[j]  <= rn;
      end
    end
  end

  assign root = rt[RB-1];

endmodule

/* design/cru_back.sv */
// ----------------------------------------------------------------------------
// cru_back
// Back end: divides, adds the start point, saturates, takes the radius and
// holds the result in the last stage until it is taken.
// ----------------------------------------------------------------------------
module cru_back import cru_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  job_t         job,
  input  logic         avail,
  output logic         pop,
  cru_circle_if.source circle
);

  localparam int C1 = DIV_LAT;
  localparam int C2 = C1 + 1;
  localparam int C3 = C2 + 1;
  localparam int C4 = C3 + 1;
  localparam int FO = C4 + RB + 1;
  localparam int L  = FO + 1;
  localparam int TW = OUT_BITS + 3;
  localparam logic signed [TW-1:0] MAXT = {{(TW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [TW-1:0] MINT = {{(TW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

  typedef struct packed {
    logic [OUT_BITS-1:0] val;
    logic                ovf;
  } sat_t;

  function automatic sat_t sat_c(input logic signed [TW-1:0] t, input logic big,
                                 input logic neg);
    sat_t r;
    if (big) begin
      r.ovf = 1'b1;
      r.val = neg ? MINT[OUT_BITS-1:0] : MAXT[OUT_BITS-1:0];
    end else if (t > MAXT) begin
      r.ovf = 1'b1;
      r.val = MAXT[OUT_BITS-1:0];
    end else if (t < MINT) begin
      r.ovf = 1'b1;
      r.val = MINT[OUT_BITS-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = t[OUT_BITS-1:0];
    end
    return r;
  endfunction

  // start + truncated offset; a dropped fraction that carries the sum across
  // zero moves it one step toward zero so the centre truncates as a whole
  function automatic logic signed [TW-1:0] trunc_sum(input logic signed [TW-1:0] t,
                                                     input logic neg, input logic inx);
    logic signed [TW-1:0] r;
    r = t;
    if (inx && !neg && (t < 0)) r = t + TW'(1);
    if (inx && neg && (t > 0))  r = t - TW'(1);
    return r;
  endfunction

  logic                  en;
  logic [L-1:0]          vld;
  bk_t                   sd    [L];
  bk_t                   sd_nx [L];
  bk_t                   in_side;
  logic signed [QW-1:0]  qx, qy;
  logic                  bgx, bgy, ngx, ngy, inx_x, inx_y;
  logic signed [TW-1:0]  tx, ty;
  sat_t                  sx, sy;
  logic signed [DXW-1:0] dx, dy;
  logic        [SMW-1:0] sqx, sqy, sm;
  logic        [RB-1:0]  root;

  assign en  = !circle.valid || circle.ready;
  assign pop = avail && en;

  cru_div u_div_x (
    .clk (clk), .en (en), .num (job.num_x), .den (job.den),
    .q (qx), .big (bgx), .neg (ngx), .inexact (inx_x)
  );

  cru_div u_div_y (
    .clk (clk), .en (en), .num (job.num_y), .den (job.den),
    .q (qy), .big (bgy), .neg (ngy), .inexact (inx_y)
  );

  cru_sqrt u_sqrt (
    .clk (clk), .en (en), .num (sm), .root (root)
  );

  always_comb begin
    in_side           = '0;
    in_side.pts       = job.pts;
    in_side.collinear = job.collinear;

    tx = trunc_sum(TW'($signed(sd[C1-1].pts.first_x)) + TW'(qx), ngx, inx_x);
    ty = trunc_sum(TW'($signed(sd[C1-1].pts.first_y)) + TW'(qy), ngy, inx_y);
    sx = sat_c(tx, bgx, ngx);
    sy = sat_c(ty, bgy, ngy);

    for (int i = 0; i < L; i++) begin
      if (i == 0) sd_nx[i] = in_side;
      else        sd_nx[i] = sd[i-1];
    end

    sd_nx[C1].ctr_x    = sx.val;
    sd_nx[C1].ctr_y    = sy.val;
    sd_nx[C1].overflow = sx.ovf | sy.ovf;

    if (root[RB-1:OUT_BITS] != '0) begin
      sd_nx[FO].radius   = '1;
      sd_nx[FO].overflow = 1'b1;
    end else begin
      sd_nx[FO].radius = root[OUT_BITS-1:0];
    end
    if (sd[FO-1].collinear) begin
      sd_nx[FO].ctr_x    = '0;
      sd_nx[FO].ctr_y    = '0;
      sd_nx[FO].radius   = '0;
      sd_nx[FO].overflow = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], avail};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        sd[i] <= sd_nx[i];
      end
      dx  <= DXW'($signed(sd[C1].pts.first_x)) - DXW'($signed(sd[C1].ctr_x));
      dy  <= DXW'($signed(sd[C1].pts.first_y)) - DXW'($signed(sd[C1].ctr_y));
      sqx <= dx * dx;
      sqy <= dy * dy;
      sm  <= sqx + sqy;
    end
  end

  assign circle.valid       = vld[L-1];
  assign circle.out_first_x = sd[L-1].pts.first_x;
  assign circle.out_first_y = sd[L-1].pts.first_y;
  assign circle.out_last_x  = sd[L-1].pts.last_x;
  assign circle.out_last_y  = sd[L-1].pts.last_y;
  assign circle.ctr_x       = sd[L-1].ctr_x;
  assign circle.ctr_y       = sd[L-1].ctr_y;
  assign circle.radius      = sd[L-1].radius;
  assign circle.collinear   = sd[L-1].collinear;
  assign circle.overflow    = sd[L-1].overflow;

endmodule

/* design/circumcentre_and_radius_unit.sv */
// ----------------------------------------------------------------------------
// circumcentre_and_radius_unit
// Circumcentre and radius of the circle through an arc's three points.
//
//   channel  dir  contents
//   arc      in   first, mid, last points (signed coordinates)
//   circle   out  first/last points, centre, radius, collinear, overflow
//
// One request per cycle sustained while the output is not stalled. The path
// runs through 6 front stages, the queue and 72 back stages (34-stage divider,
// 4 centre/square stages, 33-stage square root, output register).
// Synchronous reset clears valid state only. A stalled output freezes the
// back pipeline; the 4-entry queue lets the front keep working until full.
// ----------------------------------------------------------------------------
module circumcentre_and_radius_unit import cru_pkg::*; (
  input logic          clk,
  input logic          rst,
  cru_arc_if.sink      arc,
  cru_circle_if.source circle
);

  logic push, pop, full, avail;
  job_t job_in, job_out;

  cru_front u_front (
    .clk (clk), .rst (rst), .arc (arc), .full (full), .push (push), .job (job_in)
  );

  cru_fifo u_fifo (
    .clk (clk), .rst (rst), .push (push), .din (job_in), .pop (pop),
    .dout (job_out), .full (full), .avail (avail)
  );

  cru_back u_back (
    .clk (clk), .rst (rst), .job (job_out), .avail (avail), .pop (pop),
    .circle (circle)
  );

endmodule
